[rtl/lbs_pkg.sv]
// shared types, codes and helpers for the skinning core
package lbs_pkg;

  localparam logic [1:0] MODE_JOINT  = 2'd0;
  localparam logic [1:0] MODE_ROOT   = 2'd1;
  localparam logic [1:0] MODE_VERT   = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam logic [1:0] KIND_JOINT = 2'd0;
  localparam logic [1:0] KIND_ROOT  = 2'd1;
  localparam logic [1:0] KIND_VERT  = 2'd2;

  localparam int NBANK     = 12;
  localparam int WFRAC     = 15;
  localparam int CMD_DEPTH = 4;
  localparam int OUT_DEPTH = 8;
  localparam int CNT_W     = $clog2(OUT_DEPTH + 1);
  localparam int ACC_W     = 50;
  localparam int SUM_W     = 66;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       joint;
    logic [3:0]       elem;
    logic [31:0]      value;
    logic [2:0][31:0] pos;
    logic [2:0][31:0] norm;
    logic [3:0][7:0]  idx;
    logic [3:0][15:0] w;
    logic [3:0]       use_b;
    logic             weighted;
  } cmd_t;

  typedef struct packed {
    logic [2:0][31:0] skin;
    logic [2:0][31:0] nrm;
  } res_t;

  // column-major element to bank: columns 0..3, rows 0..2; row 3 is never used
  function automatic logic [3:0] elem_bank(input logic [3:0] e);
    return 4'(e[3:2]) * 4'd3 + 4'(e[1:0]);
  endfunction

  function automatic logic [31:0] sat32(input logic signed [SUM_W-1:0] v);
    if (v > $signed(SUM_W'(32'h7FFF_FFFF))) begin
      return 32'h7FFF_FFFF;
    end else if (v < -$signed(SUM_W'(33'h0_8000_0000))) begin
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

endpackage

[rtl/lbs_queue.sv]
// small register queue with occupancy count
module lbs_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  logic [WIDTH-1:0]             din,
  output logic                         full,
  input  logic                         pop,
  output logic [WIDTH-1:0]             dout,
  output logic                         empty,
  output logic [$clog2(DEPTH+1)-1:0]   count
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [$clog2(DEPTH+1)-1:0] cnt_r;
  logic do_push, do_pop;

  assign full    = (cnt_r == ($clog2(DEPTH+1))'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rp_r];
  assign count   = cnt_r;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (do_push ? 1'b1 : 1'b0) - (do_pop ? 1'b1 : 1'b0);
    end
  end
endmodule

[rtl/lbs_front.sv]
// front end: decodes an input word into a command for the back end
module lbs_front
  import lbs_pkg::*;
#(
  parameter int MAX_JOINTS = 256
) (
  input  logic [1:0]  mode,
  input  logic [7:0]  load_joint,
  input  logic [3:0]  load_element,
  input  logic [31:0] load_value,
  input  logic [31:0] pos_x,
  input  logic [31:0] pos_y,
  input  logic [31:0] pos_z,
  input  logic [31:0] norm_x,
  input  logic [31:0] norm_y,
  input  logic [31:0] norm_z,
  input  logic [31:0] joint_indices,
  input  logic [63:0] weight_pack,
  input  logic [8:0]  joint_count,
  output logic        keep,
  output cmd_t        cmd
);
  logic [8:0] cnt_eff;
  logic [3:0] wpos;

  assign cnt_eff = (joint_count > 9'(MAX_JOINTS)) ? 9'(MAX_JOINTS) : joint_count;

  always_comb begin
    cmd.joint = load_joint;
    cmd.elem  = load_element;
    cmd.value = load_value;
    cmd.pos   = {pos_z, pos_y, pos_x};
    cmd.norm  = {norm_z, norm_y, norm_x};
    cmd.idx   = joint_indices;
    cmd.w     = weight_pack;
    for (int k = 0; k < 4; k++) begin
      // positive weight: sign clear and not zero, with a nonzero joint count
      wpos[k] = !weight_pack[16*k+15] && (weight_pack[16*k +: 16] != 16'd0)
                && (cnt_eff != 9'd0);
      cmd.use_b[k] = wpos[k] && ({1'b0, joint_indices[8*k +: 8]} < cnt_eff);
    end
    cmd.weighted = |wpos;
    keep = 1'b0;
    cmd.kind = KIND_VERT;
    case (mode)
      MODE_JOINT: begin
        cmd.kind = KIND_JOINT;
        keep = ({1'b0, load_joint} < 9'(MAX_JOINTS));
      end
      MODE_ROOT: begin
        cmd.kind = KIND_ROOT;
        keep = 1'b1;
      end
      MODE_VERT: begin
        keep = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end
endmodule

[rtl/lbs_back.sv]
// back end: palette and root storage, transform pipeline, blend accumulator
module lbs_back
  import lbs_pkg::*;
#(
  parameter int MAX_JOINTS = 256,
  parameter int FRAC_BITS  = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cmd_valid,
  input  cmd_t             cmd,
  output logic             cmd_pop,
  input  logic [CNT_W-1:0] out_count,
  output logic             res_push,
  output res_t             res
);
  localparam int JW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;

  logic signed [31:0] pal [NBANK][MAX_JOINTS];
  logic signed [31:0] root_r [NBANK];
  logic signed [31:0] rd_r [NBANK];

  logic [1:0] slot_r;
  logic [CNT_W-1:0] infl_r;
  logic is_vert, credit_ok, issue, do_load;
  logic [3:0] wbank;
  logic [JW-1:0] raddr;

  // s1
  logic s1_v_r, s1_use_r, s1_wt_r;
  logic [1:0] s1_slot_r;
  logic [15:0] s1_w_r;
  logic signed [31:0] s1_pos_r [3];
  logic signed [31:0] s1_nrm_r [3];
  // s2
  logic s2_v_r, s2_use_r, s2_wt_r;
  logic [1:0] s2_slot_r;
  logic [15:0] s2_w_r;
  logic signed [63:0] s2_jp_r [9];
  logic signed [63:0] s2_rp_r [9];
  logic signed [63:0] s2_np_r [9];
  logic signed [31:0] s2_jt_r [3];
  logic signed [31:0] s2_rt_r [3];
  // s3
  logic s3_v_r, s3_use_r, s3_wt_r;
  logic [1:0] s3_slot_r;
  logic [15:0] s3_w_r;
  logic signed [31:0] s3_j_r [3];
  logic [31:0] s3_rpos_r [3];
  logic [31:0] s3_rnrm_r [3];
  // s4
  logic s4_v_r, s4_wt_r;
  logic [1:0] s4_slot_r;
  logic signed [47:0] s4_wp_r [3];
  logic [31:0] s4_rpos_r [3];
  logic [31:0] s4_rnrm_r [3];
  logic signed [ACC_W-1:0] acc_r [3];
  logic signed [ACC_W-1:0] acc_nxt [3];

  assign is_vert   = cmd_valid && (cmd.kind == KIND_VERT);
  assign credit_ok = (CNT_W'(infl_r + out_count) < CNT_W'(OUT_DEPTH));
  assign issue     = is_vert && ((slot_r != 2'd0) || credit_ok);
  assign do_load   = cmd_valid && (cmd.kind != KIND_VERT);
  assign cmd_pop   = do_load || (issue && (slot_r == 2'd3));
  assign wbank     = elem_bank(cmd.elem);
  assign raddr     = cmd.idx[slot_r][JW-1:0];

  // palette banks, one per used matrix element
  always_ff @(posedge clk) begin
    if (do_load && (cmd.kind == KIND_JOINT) && (cmd.elem[1:0] != 2'd3)) begin
      pal[wbank][cmd.joint[JW-1:0]] <= cmd.value;
    end
    for (int b = 0; b < NBANK; b++) begin
      rd_r[b] <= pal[b][raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int b = 0; b < NBANK; b++) begin
        root_r[b] <= ((b % 3) == (b / 3)) ? (32'sd1 <<< FRAC_BITS) : 32'sd0;
      end
      slot_r <= '0;
      infl_r <= '0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      if (do_load && (cmd.kind == KIND_ROOT) && (cmd.elem[1:0] != 2'd3)) begin
        root_r[wbank] <= cmd.value;
      end
      if (issue) begin
        slot_r <= slot_r + 2'd1;
      end
      infl_r <= infl_r + ((issue && (slot_r == 2'd0)) ? 1'b1 : 1'b0)
                - (res_push ? 1'b1 : 1'b0);
      s1_v_r <= issue;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_slot_r <= slot_r;
    s1_use_r  <= cmd.use_b[slot_r];
    s1_wt_r   <= cmd.weighted;
    s1_w_r    <= cmd.w[slot_r];
    for (int c = 0; c < 3; c++) begin
      s1_pos_r[c] <= $signed(cmd.pos[c]);
      s1_nrm_r[c] <= $signed(cmd.norm[c]);
    end
    // products; root terms are taken from the last slot
    s2_slot_r <= s1_slot_r;
    s2_use_r  <= s1_use_r;
    s2_wt_r   <= s1_wt_r;
    s2_w_r    <= s1_w_r;
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        s2_jp_r[3*c+r] <= rd_r[3*c+r] * s1_pos_r[c];
        s2_rp_r[3*c+r] <= root_r[3*c+r] * s1_pos_r[c];
        s2_np_r[3*c+r] <= root_r[3*c+r] * s1_nrm_r[c];
      end
      s2_jt_r[c] <= rd_r[9+c];
      s2_rt_r[c] <= root_r[9+c];
    end
    // floor shift, sum with translation (normals take none), saturate
    s3_slot_r <= s2_slot_r;
    s3_use_r  <= s2_use_r;
    s3_wt_r   <= s2_wt_r;
    s3_w_r    <= s2_w_r;
    for (int r = 0; r < 3; r++) begin
      s3_j_r[r] <= sat32(SUM_W'(s2_jp_r[r] >>> FRAC_BITS)
                       + SUM_W'(s2_jp_r[3+r] >>> FRAC_BITS)
                       + SUM_W'(s2_jp_r[6+r] >>> FRAC_BITS) + SUM_W'(s2_jt_r[r]));
      s3_rpos_r[r] <= sat32(SUM_W'(s2_rp_r[r] >>> FRAC_BITS)
                          + SUM_W'(s2_rp_r[3+r] >>> FRAC_BITS)
                          + SUM_W'(s2_rp_r[6+r] >>> FRAC_BITS) + SUM_W'(s2_rt_r[r]));
      s3_rnrm_r[r] <= sat32(SUM_W'(s2_np_r[r] >>> FRAC_BITS)
                          + SUM_W'(s2_np_r[3+r] >>> FRAC_BITS)
                          + SUM_W'(s2_np_r[6+r] >>> FRAC_BITS));
    end
    // weight products, skipped slots add nothing
    s4_slot_r <= s3_slot_r;
    s4_wt_r   <= s3_wt_r;
    for (int r = 0; r < 3; r++) begin
      s4_wp_r[r]   <= s3_use_r ? (48'(s3_j_r[r]) * 48'($signed({1'b0, s3_w_r[14:0]})))
                               : '0;
      s4_rpos_r[r] <= s3_rpos_r[r];
      s4_rnrm_r[r] <= s3_rnrm_r[r];
    end
    for (int r = 0; r < 3; r++) begin
      acc_r[r] <= acc_nxt[r];
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc_nxt[r] = ((s4_slot_r == 2'd0) ? '0 : acc_r[r]) + ACC_W'(s4_wp_r[r]);
      res.skin[r] = s4_wt_r ? sat32(SUM_W'(acc_nxt[r] >>> WFRAC)) : s4_rpos_r[r];
      res.nrm[r]  = s4_rnrm_r[r];
    end
  end

  assign res_push = s4_v_r && (s4_slot_r == 2'd3);
endmodule

[rtl/linear_blend_skinning_core.sv]
// top level of the four-weight linear blend skinning core
// Words enter through a queue-style port. A vertex word is worked through in
// the back end one weight slot at a time, one palette read per weight slot,
// and the next word waits until its last slot has issued; loads run at one
// per cycle while they are at the head of the command queue. The front end
// decodes words into a four-entry command queue, so the input keeps flowing
// while the back end works; results wait in an eight-entry output queue and
// a vertex is issued only when a place in it is reserved. Configuration
// (joint_count) may only be written while no words are in flight.
module linear_blend_skinning_core
  import lbs_pkg::*;
#(
  parameter int MAX_JOINTS = 256,
  parameter int FRAC_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [8:0]  cfg_wdata,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_mode,
  input  logic [7:0]  in_load_joint,
  input  logic [3:0]  in_load_element,
  input  logic signed [31:0] in_load_value,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic signed [31:0] in_norm_x,
  input  logic signed [31:0] in_norm_y,
  input  logic signed [31:0] in_norm_z,
  input  logic [31:0] in_joint_indices,
  input  logic [63:0] in_weight_pack,
  output logic        empty,
  input  logic        pop,
  output logic signed [31:0] out_skinned_x,
  output logic signed [31:0] out_skinned_y,
  output logic signed [31:0] out_skinned_z,
  output logic signed [31:0] out_normal_out_x,
  output logic signed [31:0] out_normal_out_y,
  output logic signed [31:0] out_normal_out_z
);
  logic [8:0] jc_r;
  logic keep, cq_full, cq_empty, cq_pop, res_push;
  cmd_t fe_cmd, cq_cmd;
  logic [$bits(cmd_t)-1:0] cq_dout;
  logic [$clog2(CMD_DEPTH+1)-1:0] cq_count;
  res_t be_res, oq_res;
  logic [$bits(res_t)-1:0] oq_dout;
  logic [CNT_W-1:0] oq_count;
  logic oq_full;

  // joint count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      jc_r <= '0;
    end else if (cfg_we) begin
      jc_r <= cfg_wdata;
    end
  end

  lbs_front #(.MAX_JOINTS(MAX_JOINTS)) u_front (
    .mode(in_mode), .load_joint(in_load_joint), .load_element(in_load_element),
    .load_value(in_load_value), .pos_x(in_pos_x), .pos_y(in_pos_y),
    .pos_z(in_pos_z), .norm_x(in_norm_x), .norm_y(in_norm_y),
    .norm_z(in_norm_z), .joint_indices(in_joint_indices),
    .weight_pack(in_weight_pack), .joint_count(jc_r), .keep(keep), .cmd(fe_cmd)
  );

  // dropped words (unused mode, joint slot out of range) are accepted silently
  assign full = cq_full;

  lbs_queue #(.WIDTH($bits(cmd_t)), .DEPTH(CMD_DEPTH)) u_cmd_q (
    .clk(clk), .rst_n(rst_n), .push(push && keep), .din(fe_cmd),
    .full(cq_full), .pop(cq_pop), .dout(cq_dout), .empty(cq_empty),
    .count(cq_count)
  );

  assign cq_cmd = cmd_t'(cq_dout);

  lbs_back #(.MAX_JOINTS(MAX_JOINTS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .cmd_valid(!cq_empty), .cmd(cq_cmd),
    .cmd_pop(cq_pop), .out_count(oq_count), .res_push(res_push), .res(be_res)
  );

  // result queue, never overflows thanks to the issue reservation
  lbs_queue #(.WIDTH($bits(res_t)), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk(clk), .rst_n(rst_n), .push(res_push), .din(be_res),
    .full(oq_full), .pop(pop), .dout(oq_dout), .empty(empty),
    .count(oq_count)
  );

  assign oq_res = res_t'(oq_dout);
  assign out_skinned_x    = oq_res.skin[0];
  assign out_skinned_y    = oq_res.skin[1];
  assign out_skinned_z    = oq_res.skin[2];
  assign out_normal_out_x = oq_res.nrm[0];
  assign out_normal_out_y = oq_res.nrm[1];
  assign out_normal_out_z = oq_res.nrm[2];

  // command queue occupancy and output queue full flag, otherwise unused, folded into one signal
  logic unused_ok;
  assign unused_ok = (cq_count != '0) || oq_full;
endmodule

[rtl/lbs_checker.sv]
// port-level checks for the skinning core, bound to the top level
module lbs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [31:0] out_skinned_x,
  input logic [31:0] out_normal_out_x
);
  a_empty_after_reset: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result queue not empty after reset");
  a_room_after_reset: assert property (@(posedge clk) !rst_n |=> !full)
    else $error("input full after reset");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_skinned_x)
                          && $stable(out_normal_out_x)))
    else $error("waiting result word changed");
endmodule

bind linear_blend_skinning_core lbs_checker u_lbs_checker (
  .clk(clk), .rst_n(rst_n), .full(full), .empty(empty), .pop(pop),
  .out_skinned_x(out_skinned_x), .out_normal_out_x(out_normal_out_x)
);
